FILE: rtl/core/pts_pkg.sv
// Package for the planar tile pixel store: payload structs, command codes,
// memory request struct and sizes. No dependencies.

package pts_pkg;

   localparam int ADDR_W      = 15;
   localparam int MEM_BYTES   = 32768;
   localparam int TILE_W      = 10;
   localparam int COUNT_W     = 5;

   localparam logic [2:0] CMD_LOAD_BYTE   = 3'd0;
   localparam logic [2:0] CMD_READ_BYTE   = 3'd1;
   localparam logic [2:0] CMD_READ_PIXEL  = 3'd2;
   localparam logic [2:0] CMD_WRITE_PIXEL = 3'd3;
   localparam logic [2:0] CMD_COPY_TILE   = 3'd4;

   typedef struct packed {
      logic [2:0]        command;
      logic [TILE_W-1:0] tile_number;
      logic [TILE_W-1:0] source_tile;
      logic [2:0]        pixel_x;
      logic [2:0]        pixel_y;
      logic              h_flip;
      logic              v_flip;
      logic [2:0]        palette;
      logic [3:0]        pixel_value;
      logic [ADDR_W-1:0] byte_address;
      logic [7:0]        byte_data;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] color_index;
      logic [6:0] palette_entry;
      logic [7:0] read_data;
   } rsp_payload_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
   } mem_req_type;

endpackage

FILE: rtl/core/pts_stream_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on pts_pkg for the payload structs.

interface pts_req_if;
   import pts_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pts_rsp_if;
   import pts_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/pts_plane_unit.sv
// Shared bit-plane unit: extracts one pixel bit from a plane byte and merges
// a new bit into it. Used once per plane step. Depends on nothing.

module pts_plane_unit (
   input  logic [7:0] byte_in,
   input  logic [2:0] column,
   input  logic       new_bit,
   output logic       bit_out,
   output logic [7:0] byte_out
);

   logic [2:0] bit_pos;

   // Pixel x sits at bit 7-x of each plane byte.
   assign bit_pos = ~column;
   assign bit_out = byte_in[bit_pos];

   always_comb begin
      byte_out          = byte_in;
      byte_out[bit_pos] = new_bit;
   end

endmodule

FILE: rtl/core/pts_seq.sv
// Command sequencer: decodes requests, steps the plane unit over the planes
// of a pixel, steps over the bytes of a tile copy, holds the response register.
// Depends on pts_pkg, pts_stream_if and pts_plane_unit.

module pts_seq
   import pts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        four_bpp_mode,
   pts_req_if.sink     req_chan,
   pts_rsp_if.source   rsp_chan,
   output mem_req_type mem_req,
   input  logic [7:0]  rd_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [ADDR_W-1:0]  addr_a_ff, addr_a_in;
   logic [ADDR_W-1:0]  addr_b_ff, addr_b_in;
   logic [ADDR_W-1:0]  cur_addr_ff, cur_addr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [1:0]         plane_ff, plane_in;
   logic [2:0]         column_ff, column_in;
   logic [3:0]         value_ff, value_in;
   logic [2:0]         pal_ff, pal_in;
   logic [3:0]         color_ff, color_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   req_payload_type    req;
   logic               accept;
   logic [ADDR_W-1:0]  dst_base;
   logic [ADDR_W-1:0]  src_base;
   logic [2:0]         col_flip;
   logic [2:0]         row_flip;
   logic [ADDR_W-1:0]  read_addr;
   logic [3:0]         color_next;
   logic [COUNT_W-1:0] last_count;
   logic [1:0]         last_plane;
   logic               unit_bit;
   logic [7:0]         unit_byte;

   assign req            = req_chan.payload;
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign dst_base = four_bpp_mode ? {req.tile_number, 5'd0} : {1'b0, req.tile_number, 4'd0};
   assign src_base = four_bpp_mode ? {req.source_tile, 5'd0} : {1'b0, req.source_tile, 4'd0};
   assign col_flip = req.h_flip ? ~req.pixel_x : req.pixel_x;
   assign row_flip = req.v_flip ? ~req.pixel_y : req.pixel_y;
   assign last_count = four_bpp_mode ? 5'd31 : 5'd15;
   assign last_plane = four_bpp_mode ? 2'd3 : 2'd1;

   pts_plane_unit u_plane (
      .byte_in  (rd_data),
      .column   (column_ff),
      .new_bit  (value_ff[plane_ff]),
      .bit_out  (unit_bit),
      .byte_out (unit_byte)
   );

   always_comb begin
      color_next = color_ff;
      color_next[plane_ff] = unit_bit;
      if (cmd_ff == CMD_COPY_TILE) begin
         read_addr = addr_a_ff + {{(ADDR_W-COUNT_W){1'b0}}, count_ff};
      end else if (cmd_ff == CMD_READ_BYTE) begin
         read_addr = addr_a_ff;
      end else begin
         read_addr = addr_a_ff + {{(ADDR_W-5){1'b0}}, plane_ff[1], 3'd0, plane_ff[0]};
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_a_in    = addr_a_ff;
      addr_b_in    = addr_b_ff;
      cur_addr_in  = cur_addr_ff;
      count_in     = count_ff;
      plane_in     = plane_ff;
      column_in    = column_ff;
      value_in     = value_ff;
      pal_in       = pal_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in      = req.command;
               rsp_data_in = '0;
               plane_in    = 2'd0;
               count_in    = '0;
               color_in    = 4'd0;
               column_in   = col_flip;
               value_in    = req.pixel_value;
               pal_in      = req.palette;
               unique case (req.command)
                  CMD_LOAD_BYTE: begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = req.byte_address;
                     mem_req.wr_data = req.byte_data;
                     rsp_valid_in    = 1'b1;
                  end
                  CMD_READ_BYTE: begin
                     addr_a_in = req.byte_address;
                     state_in  = S_READ;
                  end
                  CMD_READ_PIXEL, CMD_WRITE_PIXEL: begin
                     addr_a_in = dst_base + {{(ADDR_W-4){1'b0}}, row_flip, 1'b0};
                     state_in  = S_READ;
                  end
                  CMD_COPY_TILE: begin
                     addr_a_in = src_base;
                     addr_b_in = dst_base;
                     if (req.tile_number == req.source_tile) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = read_addr;
            cur_addr_in     = read_addr;
            state_in        = S_EXEC;
         end
         S_EXEC: begin
            unique case (cmd_ff)
               CMD_READ_BYTE: begin
                  rsp_data_in.read_data = rd_data;
                  rsp_valid_in          = 1'b1;
                  state_in              = S_IDLE;
               end
               CMD_COPY_TILE: begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = addr_b_ff + {{(ADDR_W-COUNT_W){1'b0}}, count_ff};
                  mem_req.wr_data = rd_data;
                  count_in        = count_ff + 5'd1;
                  if (count_ff == last_count) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_READ;
                  end
               end
               default: begin
                  color_in = color_next;
                  if (cmd_ff == CMD_WRITE_PIXEL) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = cur_addr_ff;
                     mem_req.wr_data = unit_byte;
                  end
                  plane_in = plane_ff + 2'd1;
                  if (plane_ff == last_plane) begin
                     rsp_data_in.color_index = color_next;
                     if (cmd_ff == CMD_READ_PIXEL) begin
                        rsp_data_in.palette_entry = four_bpp_mode ?
                           {pal_ff, color_next} : {2'd0, pal_ff, color_next[1:0]};
                     end
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_READ;
                  end
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      addr_a_ff   <= addr_a_in;
      addr_b_ff   <= addr_b_in;
      cur_addr_ff <= cur_addr_in;
      count_ff    <= count_in;
      plane_ff    <= plane_in;
      column_ff   <= column_in;
      value_ff    <= value_in;
      pal_ff      <= pal_in;
      color_ff    <= color_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_chan.ready)
      else $error("request taken while a command is in progress");

   assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("memory read and write issued in the same cycle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_EXEC))
      else $error("read step not followed by its execute step");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while a command is in progress");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && !four_bpp_mode &&
       (cmd_ff == CMD_READ_PIXEL || cmd_ff == CMD_WRITE_PIXEL)) |-> !plane_ff[1])
      else $error("plane step beyond the last plane in 2bpp mode");
`endif

endmodule

FILE: rtl/core/planar_tile_pixel_store_core.sv
// Top level of the planar tile pixel store: graphics memory, mode register
// and the command sequencer. Depends on pts_pkg, pts_stream_if and pts_seq.
//
//   Channel   Dir  Handshake              Contents
//   req_chan  in   valid/ready            command and its operands
//   rsp_chan  out  valid/ready            color index, palette entry, read byte
//   csr_*     in   csr_write_enable       four_bpp_mode
//
// A load byte, an unused code or a copy onto the same tile completes when accepted;
// a read byte takes one read step and one execute step, a pixel read or write one
// such pair per plane, a tile copy one per byte; pixel steps use the plane unit.
// Reset idles the sequencer, drops any pending response and clears the mode register;
// memory is undefined until written.
// A request is taken when idle and the response register is empty or transferring.

module planar_tile_pixel_store_core
   import pts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_enable,
   input  logic      csr_write_data,
   pts_req_if.sink   req_chan,
   pts_rsp_if.source rsp_chan
);

   logic        four_bpp_mode_ff;
   mem_req_type mem_req;
   logic [7:0]  rd_data_ff;
   logic [7:0]  gfx_mem [MEM_BYTES];

   always_ff @(posedge clock) begin
      if (reset) begin
         four_bpp_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         four_bpp_mode_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         gfx_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= gfx_mem[mem_req.rd_addr];
      end
   end

   pts_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .four_bpp_mode (four_bpp_mode_ff),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .mem_req       (mem_req),
      .rd_data       (rd_data_ff)
   );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for planar_tile_pixel_store_core: byte, pixel and tile copy commands
// in both pixel depths, checked against a tile memory model kept in the testbench.
// Depends on pts_pkg, the pts_req_if and pts_rsp_if interfaces and the core itself.

import pts_pkg::*;

class pixel_store_scoreboard;
   bit [7:0]        gfx_mem [MEM_BYTES];
   bit              known [MEM_BYTES];
   int              known_addrs [$];
   bit              four_bpp;
   rsp_payload_type expected_responses [$];
   int              failures;

   function void set_mode(bit four);
      four_bpp = four;
   endfunction

   function int tile_bytes();
      return four_bpp ? 32 : 16;
   endfunction

   function int tile_base(int tile);
      return (tile % (1 << TILE_W)) * tile_bytes();
   endfunction

   function void store_byte(int addr, bit [7:0] data);
      int a;
      a = addr % MEM_BYTES;
      gfx_mem[a] = data;
      if (!known[a]) begin
         known[a] = 1'b1;
         known_addrs.insert(known_addrs.size(), a);
      end
   endfunction

   function bit tile_known(int tile);
      int base;
      base = tile_base(tile);
      for (int i = 0; i < tile_bytes(); i++)
         if (!known[(base + i) % MEM_BYTES]) return 1'b0;
      return 1'b1;
   endfunction

   function int any_known_address();
      return known_addrs[$urandom_range(known_addrs.size() - 1, 0)];
   endfunction

   // Works out the response to an accepted request and updates the memory image.
   function void note_request(req_payload_type r);
      rsp_payload_type result;
      int              base, col, row, addr, dst, src;
      bit [3:0]        idx;
      result = '0;
      case (r.command)
         CMD_LOAD_BYTE: store_byte(int'(r.byte_address), r.byte_data);
         CMD_READ_BYTE: result.read_data = gfx_mem[int'(r.byte_address) % MEM_BYTES];
         CMD_READ_PIXEL, CMD_WRITE_PIXEL: begin
            base = tile_base(int'(r.tile_number));
            col = r.h_flip ? 7 - int'(r.pixel_x) : int'(r.pixel_x);
            row = r.v_flip ? 7 - int'(r.pixel_y) : int'(r.pixel_y);
            idx = '0;
            for (int p = 0; p < (four_bpp ? 4 : 2); p++) begin
               addr = (base + 2 * row + (p % 2) + (p / 2) * 16) % MEM_BYTES;
               idx[p] = gfx_mem[addr][7 - col];
               if (r.command == CMD_WRITE_PIXEL) gfx_mem[addr][7 - col] = r.pixel_value[p];
            end
            result.color_index = idx;
            if (r.command == CMD_READ_PIXEL)
               result.palette_entry =
                  7'((four_bpp ? int'(r.palette) * 16 : int'(r.palette) * 4) + int'(idx));
         end
         CMD_COPY_TILE: begin
            dst = tile_base(int'(r.tile_number));
            src = tile_base(int'(r.source_tile));
            if (dst != src)
               for (int i = 0; i < tile_bytes(); i++)
                  store_byte(dst + i, gfx_mem[(src + i) % MEM_BYTES]);
         end
         default: ;
      endcase
      expected_responses.insert(expected_responses.size(), result);
   endfunction

   function void check_response(rsp_payload_type r);
      rsp_payload_type e;
      if (expected_responses.size() == 0) begin
         $error("response transfer with no request outstanding");
         failures++;
         return;
      end
      e = expected_responses.pop_front();
      if (r.color_index !== e.color_index) begin
         $error("color_index: expected %0d, actual %0d", e.color_index, r.color_index);
         failures++;
      end
      if (r.palette_entry !== e.palette_entry) begin
         $error("palette_entry: expected %0d, actual %0d", e.palette_entry, r.palette_entry);
         failures++;
      end
      if (r.read_data !== e.read_data) begin
         $error("read_data: expected %0h, actual %0h", e.read_data, r.read_data);
         failures++;
      end
   endfunction
endclass

module testbench;
   import pts_pkg::*;

   localparam int         HALF_PERIOD    = 5;
   localparam bit         MODE_2BPP      = 1'b0;
   localparam bit         MODE_4BPP      = 1'b1;
   localparam logic [2:0] CMD_SPARE_LOW  = CMD_COPY_TILE + 3'd1;
   localparam logic [2:0] CMD_SPARE_HIGH = 3'd7;
   localparam int         TILE_LAST      = (1 << TILE_W) - 1;
   localparam int         IDLE_LIMIT     = 4000;
   localparam int         DRAIN_CYCLES   = 80;
   localparam int         POOL_SIZE      = 12;
   localparam int         PHASE_ITEMS    = 300;
   localparam int         REQ_BITS       = $bits(req_payload_type);

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_style_e;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   pts_req_if req_bus ();
   pts_rsp_if rsp_bus ();

   planar_tile_pixel_store_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus)
   );

   pixel_store_scoreboard sb = new();

   int           burst_left  = 0;
   int           idle_cycles = 0;
   int           tile_pool [POOL_SIZE];
   stall_style_e stall_style = STALL_NONE;
   int           style_left  = 0;
   int           hold_left   = 0;
   int           stall_phase = 0;
   bit           long_ready  = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) sb.check_response(rsp_bus.payload);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // The response side cycles through stall styles of random duration.
   always @(negedge clock) begin
      if (style_left == 0) begin
         stall_style = stall_style_e'($urandom_range(3, 0));
         style_left = $urandom_range(200, 20);
      end
      style_left--;
      stall_phase++;
      case (stall_style)
         STALL_NONE: rsp_bus.ready <= 1'b1;
         STALL_RANDOM: rsp_bus.ready <= 1'($urandom_range(1, 0));
         STALL_PERIODIC: rsp_bus.ready <= (stall_phase % 4 != 0);
         default: begin
            if (hold_left == 0) begin
               hold_left = $urandom_range(12, 1);
               long_ready = ~long_ready;
            end
            hold_left--;
            rsp_bus.ready <= long_ready;
         end
      endcase
   end

   function automatic req_payload_type random_fields();
      req_payload_type r;
      r = REQ_BITS'({$urandom, $urandom});
      return r;
   endfunction

   task automatic send_request(input req_payload_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(8, 1);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                                  : $urandom_range(24, 1);
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.payload <= r;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
   endtask

   task automatic load_byte(input int addr, input int data);
      req_payload_type r;
      r = random_fields();
      r.command = CMD_LOAD_BYTE;
      r.byte_address = ADDR_W'(addr);
      r.byte_data = 8'(data);
      send_request(r);
   endtask

   task automatic read_byte(input int addr);
      req_payload_type r;
      r = random_fields();
      r.command = CMD_READ_BYTE;
      r.byte_address = ADDR_W'(addr);
      send_request(r);
   endtask

   task automatic pixel_op(input logic [2:0] cmd, input int tile, input int x, input int y,
                           input bit hf, input bit vf, input int pal, input int val);
      req_payload_type r;
      r = random_fields();
      r.command = cmd;
      r.tile_number = TILE_W'(tile);
      r.pixel_x = 3'(x);
      r.pixel_y = 3'(y);
      r.h_flip = hf;
      r.v_flip = vf;
      r.palette = 3'(pal);
      r.pixel_value = 4'(val);
      send_request(r);
   endtask

   task automatic random_pixel_op(input logic [2:0] cmd, input int tile);
      pixel_op(cmd, tile, $urandom_range(7, 0), $urandom_range(7, 0),
               1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
               $urandom_range(7, 0), $urandom_range(15, 0));
   endtask

   task automatic copy_tile(input int dst, input int src);
      req_payload_type r;
      r = random_fields();
      r.command = CMD_COPY_TILE;
      r.tile_number = TILE_W'(dst);
      r.source_tile = TILE_W'(src);
      send_request(r);
   endtask

   task automatic spare_command(input logic [2:0] code);
      req_payload_type r;
      r = random_fields();
      r.command = code;
      send_request(r);
   endtask

   task automatic write_mode(input bit four);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.expected_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= four;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_mode(four);
      burst_left = 0;
   endtask

   // Pool tiles are filled by loads or by copies before any command reads them.
   task automatic run_tile_traffic(input int count);
      int issued, t, src, pick, dst;
      issued = 0;
      while (issued < count) begin
         t = tile_pool[$urandom_range(POOL_SIZE - 1, 0)];
         if (!sb.tile_known(t)) begin
            src = -1;
            foreach (tile_pool[i]) if (sb.tile_known(tile_pool[i])) src = tile_pool[i];
            if (src >= 0 && $urandom_range(3, 0) != 0) begin
               copy_tile(t, src);
               issued++;
            end else begin
               for (int i = 0; i < sb.tile_bytes(); i++)
                  load_byte(sb.tile_base(t) + i, $urandom_range(255, 0));
               issued += sb.tile_bytes();
            end
            continue;
         end
         pick = $urandom_range(99, 0);
         if (pick < 8)
            spare_command(3'($urandom_range(CMD_SPARE_HIGH, CMD_SPARE_LOW)));
         else if (pick < 16)
            load_byte($urandom_range(MEM_BYTES - 1, 0), $urandom_range(255, 0));
         else if (pick < 40)
            random_pixel_op(CMD_READ_PIXEL, t);
         else if (pick < 64)
            random_pixel_op(CMD_WRITE_PIXEL, t);
         else if (pick < 76)
            read_byte(sb.any_known_address());
         else if (pick < 84)
            load_byte(sb.tile_base(t) + $urandom_range(sb.tile_bytes() - 1, 0),
                      $urandom_range(255, 0));
         else if (pick < 96) begin
            dst = ($urandom_range(3, 0) == 0) ? $urandom_range(TILE_LAST, 0)
                                              : tile_pool[$urandom_range(POOL_SIZE - 1, 0)];
            copy_tile(dst, t);
         end else
            copy_tile(t, t);
         issued++;
      end
   endtask

   initial begin
      bit phase_modes [6];
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      phase_modes = '{MODE_2BPP, MODE_4BPP, MODE_2BPP, MODE_4BPP, MODE_2BPP, MODE_4BPP};
      tile_pool[0] = 0;
      tile_pool[1] = TILE_LAST;
      tile_pool[2] = 1;
      tile_pool[3] = TILE_LAST / 2;
      for (int i = 4; i < POOL_SIZE; i++) tile_pool[i] = $urandom_range(TILE_LAST, 0);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_mode(MODE_2BPP);
      load_byte(0, 8'hFF);
      load_byte(MEM_BYTES - 1, 8'h00);
      load_byte(1, 8'hA5);
      read_byte(0);
      read_byte(MEM_BYTES - 1);
      pixel_op(CMD_READ_PIXEL, 0, 0, 0, 1'b0, 1'b0, 7, 0);
      pixel_op(CMD_READ_PIXEL, 0, 7, 7, 1'b1, 1'b1, 7, 0);
      pixel_op(CMD_WRITE_PIXEL, 0, 3, 0, 1'b0, 1'b0, 0, 15);
      pixel_op(CMD_READ_PIXEL, 0, 3, 0, 1'b0, 1'b0, 0, 0);
      load_byte(TILE_LAST * 16, 8'h0F);
      load_byte(TILE_LAST * 16 + 1, 8'hF0);
      pixel_op(CMD_READ_PIXEL, TILE_LAST, 7, 0, 1'b0, 1'b0, 0, 0);
      pixel_op(CMD_WRITE_PIXEL, TILE_LAST, 0, 7, 1'b0, 1'b1, 3, 0);
      copy_tile(TILE_LAST, TILE_LAST);
      for (int c = CMD_SPARE_LOW; c <= CMD_SPARE_HIGH; c++) spare_command(3'(c));

      write_mode(MODE_4BPP);
      load_byte(16, 8'h3C);
      load_byte(17, 8'hC3);
      pixel_op(CMD_READ_PIXEL, 0, 0, 0, 1'b0, 1'b0, 7, 0);
      pixel_op(CMD_WRITE_PIXEL, 0, 2, 0, 1'b1, 1'b0, 7, 15);
      pixel_op(CMD_READ_PIXEL, 0, 5, 0, 1'b0, 1'b0, 7, 0);

      foreach (phase_modes[i]) begin
         write_mode(phase_modes[i]);
         run_tile_traffic(PHASE_ITEMS);
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.expected_responses.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
